// File: rtl/hss_pkg.sv
package hss_pkg;

    // Sequencer states, numbered as reported on the phase field
    typedef enum logic [2:0] {
        ST_POWERED   = 3'd0,
        ST_PON_WAIT  = 3'd1,
        ST_STATUS    = 3'd2,
        ST_INIT_WR   = 3'd3,
        ST_INIT_WAIT = 3'd4,
        ST_IDLE      = 3'd5,
        ST_CONV_WAIT = 3'd6,
        ST_DATA      = 3'd7
    } phase_t;

    // Bus transfer to start
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_STATUS  = 3'd1,
        CMD_INIT    = 3'd2,
        CMD_MEASURE = 3'd3,
        CMD_READ6   = 3'd4
    } cmd_t;

    // Event kinds carried on the input tuser
    localparam logic [1:0] KIND_FAST = 2'd0;
    localparam logic [1:0] KIND_SLOW = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_TRIGGER_PERIOD = 2'd0;
    localparam logic [1:0] CFG_POWER_ON_WAIT  = 2'd1;
    localparam logic [1:0] CFG_INIT_WAIT      = 2'd2;
    localparam logic [1:0] CFG_MEASURE_WAIT   = 2'd3;

    // Configuration reset values
    localparam logic [31:0] TRIGGER_PERIOD_RST = 32'd1000;
    localparam logic [7:0]  POWER_ON_WAIT_RST  = 8'd40;
    localparam logic [7:0]  INIT_WAIT_RST      = 8'd10;
    localparam logic [7:0]  MEASURE_WAIT_RST   = 8'd80;

    // Calibrated bit of the status byte
    localparam logic [7:0] CAL_BIT  = 8'h08;
    localparam logic [7:0] FAST_MAX = 8'hFF;

    // Sequencer control state
    typedef struct packed {
        phase_t     phase;
        logic [7:0] fast_ticks;
        logic       xfer_done;
    } ctl_t;

    // Configuration values seen by the step logic
    typedef struct packed {
        logic [31:0] trigger_period;
        logic [7:0]  power_on_wait;
        logic [7:0]  init_wait;
        logic [7:0]  measure_wait;
    } cfg_t;

endpackage

// File: rtl/hss_step.sv
module hss_step #(
    parameter int SLOW_W = 32
) (
    input  logic [1:0]        kind,
    input  logic [47:0]       rx_data,
    input  hss_pkg::ctl_t     ctl,
    input  hss_pkg::cfg_t     cfg,
    input  logic [SLOW_W-1:0] slow_ticks,
    input  logic [SLOW_W-1:0] last_trigger,
    output hss_pkg::ctl_t     ctl_next,
    output logic [SLOW_W-1:0] slow_next,
    output logic [SLOW_W-1:0] last_next,
    output hss_pkg::cmd_t     bus_command,
    output logic              sample_valid,
    output logic [19:0]       humidity_new,
    output logic [19:0]       temperature_new
);
    import hss_pkg::*;

    localparam int CMP_W = (SLOW_W > 32) ? SLOW_W : 32;

    logic [7:0]        fast_upd;
    logic [SLOW_W-1:0] slow_upd;
    logic              done_upd;
    logic [SLOW_W-1:0] slow_diff;
    logic              pon_go;
    logic              status_go;
    logic              calibrated;
    logic              init_go;
    logic              settle_go;
    logic              trig_go;
    logic              conv_go;
    logic              data_go;

    // Apply the event to the counters and the done flag
    always_comb
    begin
        fast_upd = ctl.fast_ticks;
        slow_upd = slow_ticks;
        done_upd = ctl.xfer_done;
        case (kind)
            KIND_FAST:
            begin
                if (ctl.fast_ticks != FAST_MAX)
                    fast_upd = ctl.fast_ticks + 8'd1;
            end
            KIND_SLOW: slow_upd = slow_ticks + SLOW_W'(1);
            KIND_DONE: done_upd = 1'b1;
            default: ;
        endcase
    end

    // Step conditions; the status byte is the first received byte of this event
    assign slow_diff  = slow_upd - last_trigger;
    assign calibrated = (rx_data[47:40] & CAL_BIT) != 8'h00;
    assign pon_go     = fast_upd >= cfg.power_on_wait;
    assign status_go  = done_upd;
    assign init_go    = done_upd;
    assign settle_go  = fast_upd >= cfg.init_wait;
    assign trig_go    = CMP_W'(slow_diff) >= CMP_W'(cfg.trigger_period);
    assign conv_go    = fast_upd >= cfg.measure_wait;
    assign data_go    = done_upd;

    // Unpack the six-byte read
    assign humidity_new    = {rx_data[39:32], rx_data[31:24], rx_data[23:20]};
    assign temperature_new = {rx_data[19:16], rx_data[15:8], rx_data[7:0]};

    // Next state and counters
    always_comb
    begin
        ctl_next.phase      = ctl.phase;
        ctl_next.fast_ticks = fast_upd;
        ctl_next.xfer_done  = done_upd;
        slow_next           = slow_upd;
        last_next           = last_trigger;
        case (ctl.phase)
            ST_POWERED:
            begin
                ctl_next.fast_ticks = 8'd0;
                ctl_next.phase      = ST_PON_WAIT;
            end
            ST_PON_WAIT:
            begin
                if (pon_go)
                begin
                    ctl_next.xfer_done = 1'b0;
                    ctl_next.phase     = ST_STATUS;
                end
            end
            ST_STATUS:
            begin
                if (status_go)
                begin
                    ctl_next.xfer_done = 1'b0;
                    ctl_next.phase     = calibrated ? ST_IDLE : ST_INIT_WR;
                end
            end
            ST_INIT_WR:
            begin
                if (init_go)
                begin
                    ctl_next.xfer_done  = 1'b0;
                    ctl_next.fast_ticks = 8'd0;
                    ctl_next.phase      = ST_INIT_WAIT;
                end
            end
            ST_INIT_WAIT:
            begin
                if (settle_go)
                    ctl_next.phase = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (trig_go)
                begin
                    last_next           = slow_upd;
                    ctl_next.xfer_done  = 1'b0;
                    ctl_next.fast_ticks = 8'd0;
                    ctl_next.phase      = ST_CONV_WAIT;
                end
            end
            ST_CONV_WAIT:
            begin
                if (conv_go)
                begin
                    ctl_next.xfer_done = 1'b0;
                    ctl_next.phase     = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (data_go)
                begin
                    ctl_next.xfer_done = 1'b0;
                    ctl_next.phase     = ST_IDLE;
                end
            end
            default: ;
        endcase
    end

    // Command and sample strobe
    always_comb
    begin
        bus_command  = CMD_NONE;
        sample_valid = 1'b0;
        case (ctl.phase)
            ST_PON_WAIT:  if (pon_go) bus_command = CMD_STATUS;
            ST_STATUS:    if (status_go && !calibrated) bus_command = CMD_INIT;
            ST_IDLE:      if (trig_go) bus_command = CMD_MEASURE;
            ST_CONV_WAIT: if (conv_go) bus_command = CMD_READ6;
            ST_DATA:      sample_valid = data_go;
            default: ;
        endcase
    end

endmodule

// File: rtl/humidity_sensor_sequencer_top.sv
// Humidity and temperature sensor readout sequencer.
// Input stream: one transaction per event. tuser carries the event kind
// (fast tick, slow tick, bus transfer done), tdata the received bytes with
// the first byte in bits 47:40. Each event yields exactly one output
// transaction with the bus command to start, the latest raw humidity and
// temperature, a new-sample flag and the sequencer phase after the step.
// The result passes one input register, then the step logic feeding the
// output register. One event is taken per cycle while the output is not
// stalled.
// A stalled output holds its data; the input register keeps filling until
// both stages are full, then s_axis_tready drops.
// Configuration: cfg_we writes cfg_data to the register at cfg_index in the
// same cycle; write only while no event is in flight.
// Reset clears the pipeline, returns the sequencer to the powered-on state,
// zeroes counters and samples, and loads the default configuration.
module humidity_sensor_sequencer_top #(
    parameter int SLOW_COUNT_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // rx_data[47:0]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bus_command[2:0], humidity_raw[22:3], temperature_raw[42:23],
    // sample_valid[43], phase[46:44], zero fill[47]
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import hss_pkg::*;

    logic                        in_valid_reg;
    logic [1:0]                  in_kind_reg;
    logic [47:0]                 in_data_reg;
    logic                        out_valid_reg;
    logic [47:0]                 out_data_reg;
    logic [47:0]                 out_data_next;
    ctl_t                        ctl_reg;
    ctl_t                        ctl_next;
    cfg_t                        cfg_reg;
    logic [SLOW_COUNT_WIDTH-1:0] slow_reg;
    logic [SLOW_COUNT_WIDTH-1:0] slow_next;
    logic [SLOW_COUNT_WIDTH-1:0] last_reg;
    logic [SLOW_COUNT_WIDTH-1:0] last_next;
    logic [19:0]                 hum_reg;
    logic [19:0]                 temp_reg;
    logic [19:0]                 hum_new;
    logic [19:0]                 temp_new;
    logic [19:0]                 hum_out;
    logic [19:0]                 temp_out;
    cmd_t                        cmd;
    logic                        sample;
    logic                        out_ready;
    logic                        step;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    hss_step #(
        .SLOW_W (SLOW_COUNT_WIDTH)
    ) u_step (
        .kind            (in_kind_reg),
        .rx_data         (in_data_reg),
        .ctl             (ctl_reg),
        .cfg             (cfg_reg),
        .slow_ticks      (slow_reg),
        .last_trigger    (last_reg),
        .ctl_next        (ctl_next),
        .slow_next       (slow_next),
        .last_next       (last_next),
        .bus_command     (cmd),
        .sample_valid    (sample),
        .humidity_new    (hum_new),
        .temperature_new (temp_new)
    );

    // Pack the result
    assign hum_out       = sample ? hum_new : hum_reg;
    assign temp_out      = sample ? temp_new : temp_reg;
    assign out_data_next = {1'b0, ctl_next.phase, sample, temp_out, hum_out, cmd};

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= out_data_next;
    end

    // Advance sequencer state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg.phase      <= ST_POWERED;
            ctl_reg.fast_ticks <= 8'd0;
            ctl_reg.xfer_done  <= 1'b0;
            slow_reg           <= '0;
            last_reg           <= '0;
            hum_reg            <= 20'd0;
            temp_reg           <= 20'd0;
        end
        else if (step)
        begin
            ctl_reg  <= ctl_next;
            slow_reg <= slow_next;
            last_reg <= last_next;
            hum_reg  <= hum_out;
            temp_reg <= temp_out;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_period <= TRIGGER_PERIOD_RST;
            cfg_reg.power_on_wait  <= POWER_ON_WAIT_RST;
            cfg_reg.init_wait      <= INIT_WAIT_RST;
            cfg_reg.measure_wait   <= MEASURE_WAIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIGGER_PERIOD: cfg_reg.trigger_period <= cfg_data;
                CFG_POWER_ON_WAIT:  cfg_reg.power_on_wait  <= cfg_data[7:0];
                CFG_INIT_WAIT:      cfg_reg.init_wait      <= cfg_data[7:0];
                CFG_MEASURE_WAIT:   cfg_reg.measure_wait   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule
